### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Assertion helpers, included by the sound shift register generator unit.
// All checks sample on the rising edge of clock and are off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate implication: the consequent holds in the same cycle.
`define ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: the consequent holds in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/ssrg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sound shift register generator package
// Shared widths, operation codes, control byte layout and reset values.
// ----------------------------------------------------------------------------
package ssrg_pkg;

   localparam int PATTERN_BITS = 24;
   localparam int DATA_BITS    = 24;
   localparam int PERIOD_BITS  = 8;
   localparam int CTRL_BITS    = 8;
   localparam int SAMPLE_BITS  = 8;
   localparam int VOLUME_BITS  = 4;

   typedef logic [1:0]             opcode_type;
   typedef logic [PERIOD_BITS-1:0] period_type;
   typedef logic [CTRL_BITS-1:0]   ctrl_type;
   typedef logic [SAMPLE_BITS-1:0] sample_type;

   localparam opcode_type OP_LOAD = 2'd0;
   localparam opcode_type OP_TICK = 2'd1;
   localparam opcode_type OP_ACK  = 2'd2;

   // Configuration register indexes
   localparam logic CSR_FAST_PERIOD = 1'b0;
   localparam logic CSR_SLOW_PERIOD = 1'b1;

   // Control byte bit positions
   localparam int CTRL_FAST_BIT   = 5;
   localparam int CTRL_RECIRC_BIT = 6;
   localparam int CTRL_ENABLE_BIT = 7;

   localparam period_type FAST_PERIOD_RESET = 8'd11;
   localparam period_type SLOW_PERIOD_RESET = 8'd44;

endpackage

### design/sound_shift_register_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sound shift register generator
// Video chip sound source: shift register pattern, noise bit, period divider
// and one-shot sound interrupt; one sample beat per tick beat.
// ----------------------------------------------------------------------------
//  channel   ports                        direction  handshake
//  request   req_valid/req_stall/req_*    in         valid, stall
//  response  rsp_valid/rsp_stall/rsp_*    out        valid, stall
//  config    csr_write_enable/index/data  in         write enable only
//
//  One beat per clock while req_stall is low; a tick's sample is registered
//  and appears in the cycle after acceptance. State updates in the accept
//  cycle, so the next beat may follow at once. The single output register
//  holds a stalled sample; req_stall rises only while that register is full and rsp_stall is high.
//  Reset is synchronous; it clears generator state and the valid flag, not the
//  sample or irq outputs, and reloads the period registers with their defaults.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sound_shift_register_generator_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  ssrg_pkg::opcode_type                 req_opcode,
   input  logic [ssrg_pkg::DATA_BITS-1:0]       req_shift_data,
   input  logic                                 req_noise_enable,
   input  logic                                 req_master_enable,
   input  logic                                 req_irq_enable,
   input  ssrg_pkg::ctrl_type                   req_sound_control,
   input  logic                                 req_random_bit,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output ssrg_pkg::sample_type                 rsp_sample,
   output logic                                 rsp_irq_request,
   // configuration
   input  logic                                 csr_write_enable,
   input  logic                                 csr_index,
   input  ssrg_pkg::period_type                 csr_write_data
);
   import ssrg_pkg::*;

   // configuration
   period_type fast_period_ff;
   period_type slow_period_ff;

   // generator state
   logic [PATTERN_BITS-1:0] pattern_ff,      pattern_in;
   period_type              period_count_ff, period_count_in;
   logic                    noise_mode_ff,   noise_mode_in;
   logic                    irq_allowed_ff,  irq_allowed_in;
   logic                    noise_bit_ff,    noise_bit_in;
   logic                    irq_pending_ff,  irq_pending_in;

   // output register
   logic       rsp_valid_ff,   rsp_valid_in;
   sample_type rsp_sample_ff,  rsp_sample_in;
   logic       rsp_irq_ff,     rsp_irq_in;

   logic                    req_accept;
   logic                    tick_accept;
   logic                    load_accept;
   logic                    tick_enabled;
   logic                    tick_recirc;
   period_type              tick_period;
   period_type              count_inc;
   logic                    period_done;
   logic                    tick_raise;
   sample_type              tick_sample;
   logic [31:0]             load_data_ext;
   logic [PATTERN_BITS-1:0] pattern_shifted;

   assign req_stall   = rsp_valid_ff & rsp_stall;
   assign req_accept  = req_valid & ~req_stall;
   assign tick_accept = req_accept & (req_opcode == OP_TICK);
   assign load_accept = req_accept & (req_opcode == OP_LOAD);

   // tick decode
   assign tick_enabled = req_sound_control[CTRL_ENABLE_BIT];
   assign tick_recirc  = req_sound_control[CTRL_RECIRC_BIT];
   assign tick_period  = req_sound_control[CTRL_FAST_BIT] ? fast_period_ff : slow_period_ff;
   assign count_inc    = period_count_ff + 8'd1;
   // a zero period compares true on every tick, same as a period of one
   assign period_done  = (count_inc >= tick_period);
   assign tick_raise   = period_done & tick_enabled & irq_allowed_ff & ~irq_pending_ff;
   assign tick_sample  = (tick_enabled & (pattern_ff[0] ^ noise_bit_ff))
                         ? {req_sound_control[VOLUME_BITS-1:0], 4'b0000}
                         : '0;

   assign load_data_ext   = {{(32 - DATA_BITS){1'b0}}, req_shift_data};
   assign pattern_shifted = {tick_recirc & pattern_ff[0], pattern_ff[PATTERN_BITS-1:1]};

   always_comb begin
      pattern_in      = pattern_ff;
      period_count_in = period_count_ff;
      noise_mode_in   = noise_mode_ff;
      irq_allowed_in  = irq_allowed_ff;
      noise_bit_in    = noise_bit_ff;
      irq_pending_in  = irq_pending_ff;
      rsp_sample_in   = rsp_sample_ff;
      rsp_irq_in      = rsp_irq_ff;
      rsp_valid_in    = rsp_valid_ff & rsp_stall;
      if (req_accept) begin
         unique case (req_opcode)
            OP_LOAD: begin
               pattern_in      = load_data_ext[PATTERN_BITS-1:0];
               noise_mode_in   = req_noise_enable;
               irq_allowed_in  = req_irq_enable;
               period_count_in = '0;
               noise_bit_in    = req_master_enable & req_noise_enable & req_random_bit;
            end
            OP_TICK: begin
               rsp_valid_in    = 1'b1;
               rsp_sample_in   = tick_sample;
               rsp_irq_in      = tick_raise;
               period_count_in = count_inc;
               if (period_done) begin
                  period_count_in = '0;
                  pattern_in      = pattern_shifted;
                  noise_bit_in    = tick_enabled & noise_mode_ff & req_random_bit;
                  if (tick_raise) begin
                     irq_pending_in = 1'b1;
                  end
               end
            end
            OP_ACK: begin
               irq_pending_in = 1'b0;
            end
            default: begin
               // unused code: drop the beat
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fast_period_ff  <= FAST_PERIOD_RESET;
         slow_period_ff  <= SLOW_PERIOD_RESET;
         pattern_ff      <= '0;
         period_count_ff <= '0;
         noise_mode_ff   <= 1'b0;
         irq_allowed_ff  <= 1'b0;
         noise_bit_ff    <= 1'b0;
         irq_pending_ff  <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_FAST_PERIOD: fast_period_ff <= csr_write_data;
               CSR_SLOW_PERIOD: slow_period_ff <= csr_write_data;
               default:         fast_period_ff <= fast_period_ff;
            endcase
         end
         pattern_ff      <= pattern_in;
         period_count_ff <= period_count_in;
         noise_mode_ff   <= noise_mode_in;
         irq_allowed_ff  <= irq_allowed_in;
         noise_bit_ff    <= noise_bit_in;
         irq_pending_ff  <= irq_pending_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_sample_ff <= rsp_sample_in;
      rsp_irq_ff    <= rsp_irq_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample      = rsp_sample_ff;
   assign rsp_irq_request = rsp_irq_ff;

   `ASSERT_NEXT(a_tick_gives_rsp, tick_accept, rsp_valid_ff, "tick beat without response")
   `ASSERT_SAME(a_stall_only_when_full, req_stall, rsp_valid_ff, "stall while output empty")
   `ASSERT_NEXT(a_load_clears_count, load_accept, period_count_ff == '0, "count kept after load")
   `ASSERT_NEXT(a_raise_pending, tick_accept && tick_raise, irq_pending_ff, "irq not pending")

endmodule
